### hw/rtl/vfsg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfsg_pkg
// Shared types and constants of the vector font stroke generator: payload
// structs, operation and status codes, and the transform tag.
// ----------------------------------------------------------------------------
package vfsg_pkg;

  // Glyph memory geometry. All glyph addresses wrap modulo FONT_WORDS.
  localparam int FONT_WORDS = 4096;
  localparam int AW         = 12;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_DRAW   = 2'd1;
  localparam logic [1:0] OP_ORIGIN = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_POINT   = 3'd0;
  localparam logic [2:0] ST_ADVANCE = 3'd1;
  localparam logic [2:0] ST_ILLEGAL = 3'd2;
  localparam logic [2:0] ST_SPECIAL = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;
  localparam logic [2:0] ST_ACK     = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COS    = 2'd0;
  localparam logic [1:0] CFG_SIN    = 2'd1;
  localparam logic [1:0] CFG_ASPECT = 2'd2;
  localparam logic [1:0] CFG_PEN    = 2'd3;

  // Printable character range and stroke word fields.
  localparam logic [7:0] CHAR_FIRST = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd126;
  localparam logic [1:0] STROKE_TAG = 2'b01;

  typedef struct packed {
    logic [1:0]         op;
    logic [11:0]        load_address;
    logic [15:0]        load_word;
    logic [7:0]         char_code;
    logic signed [31:0] new_origin_x;
    logic signed [31:0] new_origin_y;
  } vfsg_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               pen_draw;
    logic [2:0]         status;
    logic               last;
  } vfsg_out_t;

  // Control bits that travel alongside an operand pair through the transform.
  typedef struct packed {
    logic       emit;      // produce a result beat
    logic       adv;       // origin advance rather than a stroke point
    logic       pen_draw;
    logic [2:0] status;
    logic       last;
  } vfsg_tag_t;

endpackage : vfsg_pkg
`default_nettype wire

### hw/rtl/vfsg_font_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfsg_font_mem
// Glyph word store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module vfsg_font_mem
  import vfsg_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [15:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [15:0]   rd_data_r
);

  logic [15:0] mem [FONT_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule : vfsg_font_mem
`default_nettype wire

### hw/rtl/vfsg_xform.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfsg_xform
// Four-stage rotate, scale and translate pipeline. Takes a signed operand
// pair (a, b) and returns sat(a*cos - b*sin + ox) and
// sat(round((a*sin + b*cos) * aspect / 4096) + oy).
// ----------------------------------------------------------------------------
module vfsg_xform
  import vfsg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  input  wire logic signed [8:0]  in_a,
  input  wire logic signed [8:0]  in_b,
  input  wire vfsg_tag_t          in_tag,
  input  wire logic signed [31:0] cos_term,
  input  wire logic signed [31:0] sin_term,
  input  wire logic [15:0]        aspect,
  input  wire logic signed [31:0] origin_x,
  input  wire logic signed [31:0] origin_y,
  output logic                    out_vld_r,
  output logic signed [31:0]      out_x_r,
  output logic signed [31:0]      out_y_r,
  output vfsg_tag_t               out_tag_r
);

  localparam logic signed [42:0] XMAX = 43'sd2147483647;
  localparam logic signed [42:0] XMIN = -43'sd2147483648;
  localparam logic signed [47:0] YMAX = 48'sd2147483647;
  localparam logic signed [47:0] YMIN = -48'sd2147483648;

  logic               v1_r, v2_r, v3_r;
  vfsg_tag_t          t1_r, t2_r, t3_r;
  logic signed [40:0] acos_r, bsin_r, asin_r, bcos_r;
  logic signed [41:0] sx2_r, sy2_r, sx3_r;
  logic signed [58:0] ym3_r;

  logic signed [42:0] xsum;
  logic signed [58:0] yrnd;
  logic signed [46:0] yq;
  logic signed [47:0] ysum;
  logic signed [31:0] xsat, ysat;

  always_comb begin
    xsum = 43'(sx3_r) + 43'(origin_x);
    // Adding half an LSB and flooring rounds ties toward +infinity.
    yrnd = ym3_r + 59'sd2048;
    yq   = yrnd[58:12];
    ysum = 48'(yq) + 48'(origin_y);
    if (xsum > XMAX) begin
      xsat = XMAX[31:0];
    end else if (xsum < XMIN) begin
      xsat = XMIN[31:0];
    end else begin
      xsat = xsum[31:0];
    end
    if (ysum > YMAX) begin
      ysat = YMAX[31:0];
    end else if (ysum < YMIN) begin
      ysat = YMIN[31:0];
    end else begin
      ysat = ysum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      v1_r      <= in_vld;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      out_vld_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_r      <= in_tag;
    acos_r    <= 41'(in_a) * 41'(cos_term);
    bsin_r    <= 41'(in_b) * 41'(sin_term);
    asin_r    <= 41'(in_a) * 41'(sin_term);
    bcos_r    <= 41'(in_b) * 41'(cos_term);
    t2_r      <= t1_r;
    sx2_r     <= 42'(acos_r) - 42'(bsin_r);
    sy2_r     <= 42'(asin_r) + 42'(bcos_r);
    t3_r      <= t2_r;
    sx3_r     <= sx2_r;
    ym3_r     <= 59'(sy2_r) * 59'($signed({1'b0, aspect}));
    out_tag_r <= t3_r;
    out_x_r   <= xsat;
    out_y_r   <= ysat;
  end

endmodule : vfsg_xform
`default_nettype wire

### hw/rtl/vector_font_stroke_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vector_font_stroke_generator_core
// Vector font glyph decoder: loads glyph words, draws characters as stroke
// points in Q18.14 and keeps the pen origin.
// ----------------------------------------------------------------------------
// A load or set-origin command answers with one ack beat in the cycle after
// it is taken and leaves busy low. A draw command with the pen down holds busy
// high while it emits its strokes, at most MAX_STROKES of them: reads of the
// glyph header, the stroke pointer and the first stroke word, then one stroke
// word per cycle from the single read port of the glyph memory (none when the
// glyph has no strokes), then the four-stage transform pipeline and the origin
// advance. With the pen up a draw skips the stroke reads and only advances the
// origin. An illegal character or a special glyph ends without the transform.
// Results leave as single-cycle out_valid beats, one per cycle at most, and
// must be taken when shown: the receiver cannot stall.
// Configuration may be written only while busy is low and no result is due.
// ----------------------------------------------------------------------------
module vector_font_stroke_generator_core
  import vfsg_pkg::*;
#(
  parameter int MAX_STROKES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire vfsg_in_t    in_item,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  output logic             out_valid,
  output vfsg_out_t        out_item
);

  localparam int         CW     = $clog2(MAX_STROKES + 1);
  localparam logic [7:0] MAX8   = 8'(MAX_STROKES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_STROKES);

  typedef enum logic [2:0] {
    S_IDLE, S_HDR, S_OFS, S_FIRST, S_STREAM, S_TAIL, S_ADV, S_DRAIN
  } state_t;

  state_t             state_r;
  logic signed [31:0] cos_r, sin_r, origin_x_r, origin_y_r;
  logic [15:0]        aspect_r;
  logic               pen_r;
  logic               out_valid_r;
  vfsg_out_t          out_item_r;
  logic [AW-1:0]      hdr_addr_r, base_r;
  logic [7:0]         nvec_r, gap_r;
  logic [CW-1:0]      cnt_r, idx_r;
  logic               trunc_r, points_r;
  logic               pend_vld_r, pend_last_r;

  logic          accept, legal;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;
  logic [7:0]    glyph;
  logic [CW-1:0] cnt_first;

  logic               xf_vld;
  logic signed [8:0]  xf_a, xf_b;
  vfsg_tag_t          xf_tag;
  logic               xf_out_vld;
  logic signed [31:0] xf_x, xf_y;
  vfsg_tag_t          xf_out_tag;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign legal     = (in_item.char_code >= CHAR_FIRST) && (in_item.char_code <= CHAR_LAST);
  assign glyph     = in_item.char_code - CHAR_FIRST;
  assign mem_we    = accept && (in_item.op == OP_LOAD);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cnt_first = (nvec_r > MAX8) ? MAXC : nvec_r[CW-1:0];

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = hdr_addr_r;
    case (state_r)
      S_IDLE: begin
        mem_re    = accept && (in_item.op == OP_DRAW) && legal;
        mem_raddr = AW'({glyph, 1'b0});
      end
      S_HDR: begin
        mem_re    = 1'b1;
        mem_raddr = hdr_addr_r | AW'(1);
      end
      S_OFS: begin
        // The stroke offset wraps modulo the memory size.
        mem_re    = 1'b1;
        mem_raddr = mem_rdata[AW-1:0];
      end
      S_STREAM: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(base_r + AW'(idx_r));
      end
      default: begin
        mem_re    = 1'b0;
        mem_raddr = hdr_addr_r;
      end
    endcase
  end

  // A stroke word read last cycle goes in ahead of the closing advance.
  always_comb begin
    xf_vld          = pend_vld_r || (state_r == S_ADV);
    xf_a            = 9'($signed(mem_rdata[13:7]));
    xf_b            = 9'($signed(mem_rdata[6:0]));
    xf_tag.emit     = 1'b1;
    xf_tag.adv      = 1'b0;
    xf_tag.pen_draw = !mem_rdata[14];
    xf_tag.status   = (pend_last_r && trunc_r) ? ST_TRUNC : ST_POINT;
    xf_tag.last     = pend_last_r;
    if (!pend_vld_r) begin
      xf_a            = $signed({1'b0, gap_r});
      xf_b            = 9'sd0;
      xf_tag.emit     = !points_r;
      xf_tag.adv      = 1'b1;
      xf_tag.pen_draw = 1'b0;
      xf_tag.status   = ST_ADVANCE;
      xf_tag.last     = 1'b1;
    end
  end

  vfsg_font_mem u_mem (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (in_item.load_address),
    .wr_data   (in_item.load_word),
    .rd_en     (mem_re),
    .rd_addr   (mem_raddr),
    .rd_data_r (mem_rdata)
  );

  vfsg_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (xf_vld),
    .in_a      (xf_a),
    .in_b      (xf_b),
    .in_tag    (xf_tag),
    .cos_term  (cos_r),
    .sin_term  (sin_r),
    .aspect    (aspect_r),
    .origin_x  (origin_x_r),
    .origin_y  (origin_y_r),
    .out_vld_r (xf_out_vld),
    .out_x_r   (xf_x),
    .out_y_r   (xf_y),
    .out_tag_r (xf_out_tag)
  );

  // Control state, configuration, origin and the result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cos_r       <= 32'sd16384;
      sin_r       <= 32'sd0;
      aspect_r    <= 16'd4096;
      pen_r       <= 1'b1;
      origin_x_r  <= 32'sd0;
      origin_y_r  <= 32'sd0;
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      pend_vld_r  <= (state_r == S_STREAM);
      if (cfg_we) begin
        case (cfg_index)
          CFG_COS:    cos_r    <= cfg_wdata;
          CFG_SIN:    sin_r    <= cfg_wdata;
          CFG_ASPECT: aspect_r <= cfg_wdata[15:0];
          CFG_PEN:    pen_r    <= cfg_wdata[0];
          default:    pen_r    <= pen_r;
        endcase
      end
      if (xf_out_vld) begin
        out_valid_r <= xf_out_tag.emit;
        if (xf_out_tag.adv) begin
          origin_x_r <= xf_x;
          origin_y_r <= xf_y;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_item.op)
              OP_LOAD:   out_valid_r <= 1'b1;
              OP_ORIGIN: begin
                out_valid_r <= 1'b1;
                origin_x_r  <= in_item.new_origin_x;
                origin_y_r  <= in_item.new_origin_y;
              end
              OP_DRAW: begin
                if (legal) begin
                  state_r <= S_HDR;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_HDR:    state_r <= pen_r ? S_OFS : S_ADV;
        S_OFS:    state_r <= S_FIRST;
        S_FIRST: begin
          if (mem_rdata[15:14] != STROKE_TAG) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (cnt_first == '0) begin
            state_r <= S_ADV;
          end else begin
            state_r <= S_STREAM;
          end
        end
        S_STREAM: begin
          if (idx_r == CW'(cnt_r - 1'b1)) begin
            state_r <= S_TAIL;
          end
        end
        S_TAIL:   state_r <= S_ADV;
        S_ADV:    state_r <= S_DRAIN;
        S_DRAIN: begin
          if (xf_out_vld && xf_out_tag.adv) begin
            state_r <= S_IDLE;
          end
        end
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  // Payload and per-character working registers.
  always_ff @(posedge clk) begin
    if (xf_out_vld) begin
      out_item_r.point_x  <= xf_x;
      out_item_r.point_y  <= xf_y;
      out_item_r.pen_draw <= xf_out_tag.pen_draw;
      out_item_r.status   <= xf_out_tag.status;
      out_item_r.last     <= xf_out_tag.last;
    end
    pend_last_r <= (idx_r == CW'(cnt_r - 1'b1));
    case (state_r)
      S_IDLE: begin
        hdr_addr_r          <= AW'({glyph, 1'b0});
        points_r            <= 1'b0;
        out_item_r.pen_draw <= 1'b0;
        out_item_r.last     <= 1'b1;
        case (in_item.op)
          OP_LOAD: begin
            out_item_r.point_x <= 32'sd0;
            out_item_r.point_y <= 32'sd0;
            out_item_r.status  <= ST_ACK;
          end
          OP_ORIGIN: begin
            out_item_r.point_x <= in_item.new_origin_x;
            out_item_r.point_y <= in_item.new_origin_y;
            out_item_r.status  <= ST_ACK;
          end
          default: begin
            out_item_r.point_x <= origin_x_r;
            out_item_r.point_y <= origin_y_r;
            out_item_r.status  <= ST_ILLEGAL;
          end
        endcase
      end
      S_HDR: begin
        nvec_r <= mem_rdata[7:0];
        gap_r  <= mem_rdata[15:8];
      end
      S_OFS: begin
        base_r <= mem_rdata[AW-1:0];
      end
      S_FIRST: begin
        cnt_r               <= cnt_first;
        idx_r               <= '0;
        trunc_r             <= (nvec_r > MAX8);
        points_r            <= (cnt_first != '0);
        out_item_r.point_x  <= origin_x_r;
        out_item_r.point_y  <= origin_y_r;
        out_item_r.pen_draw <= 1'b0;
        out_item_r.status   <= ST_SPECIAL;
        out_item_r.last     <= 1'b1;
      end
      S_STREAM: begin
        idx_r <= CW'(idx_r + 1'b1);
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

endmodule : vector_font_stroke_generator_core
`default_nettype wire

### tb/vector_font_stroke_generator_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_font_stroke_generator_core_test
// Self-checking bench for the stroke generator core. Commands go in from a
// queue with random gaps between them. A behavioral copy of the glyph decoder
// predicts every result beat, and each beat that comes out is compared with
// the oldest prediction. The bench fills a stroke pool, then walks the corner
// cases: saturation, truncation, special glyphs, address wrap and illegal
// codes. Random phases follow under several rotation, scale and pen settings.
// ----------------------------------------------------------------------------
module vector_font_stroke_generator_core_test;
  import vfsg_pkg::*;

  localparam int         MAX_STROKES   = 64;
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         POOL_BASE     = 12'hFB0;
  localparam int         POOL_WORDS    = 80;
  localparam int         PHASE_ITEMS   = 16;
  localparam int         SETTLE_CYCLES = 80;
  localparam int         MAX_REPORTS   = 10;
  localparam longint     I32_MAX       = 64'sd2147483647;
  localparam longint     I32_MIN       = -64'sd2147483648;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  vfsg_in_t    in_item = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_COS;
  logic [31:0] cfg_wdata = '0;
  logic        out_valid;
  vfsg_out_t   out_item;

  vector_font_stroke_generator_core #(
    .MAX_STROKES(MAX_STROKES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Command stream and the generator's view of which font words hold data.
  vfsg_in_t    stroke_cmds[$];
  logic [15:0] gen_words[FONT_WORDS];
  bit          gen_known[FONT_WORDS];

  // Decoder state as the bench predicts it.
  logic [15:0] font_words[FONT_WORDS];
  longint      org_x = 0;
  longint      org_y = 0;
  longint      k_cos = 16384;
  longint      k_sin = 0;
  longint      k_aspect = 4096;
  logic        k_pen = 1'b1;
  vfsg_out_t   expected_pts[$];

  int          fail_count = 0;
  int          idle_left = 0;
  int          calm_left = 0;
  vfsg_out_t   want_pt;

  task automatic flag(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", what);
  endtask

  function automatic longint clamp32(input longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  // Divide by 4096 rounding to nearest, ties toward plus infinity.
  function automatic longint round_q12(input longint v);
    return (v + 2048) >>> 12;
  endfunction

  function automatic logic [15:0] font_at(input longint a);
    return font_words[a[AW-1:0]];
  endfunction

  task automatic push_expect(input longint x, input longint y, input logic draw,
                             input logic [2:0] st, input logic fin);
    vfsg_out_t r;
    r.point_x  = 32'(clamp32(x));
    r.point_y  = 32'(clamp32(y));
    r.pen_draw = draw;
    r.status   = st;
    r.last     = fin;
    expected_pts.push_back(r);
  endtask

  task automatic render_cmd(input vfsg_in_t it);
    longint      g, gap, base, ix, iy;
    logic [15:0] hdr, w;
    int          nvec, cnt;
    case (it.op)
      OP_LOAD: begin
        font_words[it.load_address] = it.load_word;
        push_expect(0, 0, 1'b0, ST_ACK, 1'b1);
      end
      OP_ORIGIN: begin
        org_x = it.new_origin_x;
        org_y = it.new_origin_y;
        push_expect(org_x, org_y, 1'b0, ST_ACK, 1'b1);
      end
      OP_DRAW: begin
        if (it.char_code < CHAR_FIRST || it.char_code > CHAR_LAST) begin
          push_expect(org_x, org_y, 1'b0, ST_ILLEGAL, 1'b1);
          return;
        end
        g    = it.char_code - CHAR_FIRST;
        hdr  = font_at(2 * g);
        nvec = hdr[7:0];
        gap  = hdr[15:8];
        cnt  = 0;
        if (k_pen) begin
          base = longint'($signed(font_at(2 * g + 1)));
          w    = font_at(base);
          if (w[15:14] != STROKE_TAG) begin
            push_expect(org_x, org_y, 1'b0, ST_SPECIAL, 1'b1);
            return;
          end
          cnt = (nvec > MAX_STROKES) ? MAX_STROKES : nvec;
          for (int i = 0; i < cnt; i++) begin
            w  = font_at(base + i);
            ix = $signed(w[13:7]);
            iy = $signed(w[6:0]);
            push_expect(ix * k_cos - iy * k_sin + org_x,
                        round_q12((ix * k_sin + iy * k_cos) * k_aspect) + org_y,
                        !w[14],
                        (i == cnt - 1 && nvec > MAX_STROKES) ? ST_TRUNC : ST_POINT,
                        i == cnt - 1);
          end
        end
        org_x = clamp32(org_x + k_cos * gap);
        org_y = clamp32(org_y + round_q12(k_sin * gap * k_aspect));
        if (cnt == 0) push_expect(org_x, org_y, 1'b0, ST_ADVANCE, 1'b1);
      end
      default: ;
    endcase
  endtask

  // ---- command generation --------------------------------------------------

  function automatic vfsg_in_t scrambled(input logic [1:0] op);
    vfsg_in_t it;
    it.op           = op;
    it.load_address = 12'($urandom);
    it.load_word    = 16'($urandom);
    it.char_code    = 8'($urandom);
    it.new_origin_x = $urandom;
    it.new_origin_y = $urandom;
    return it;
  endfunction

  task automatic push_cmd(input vfsg_in_t it);
    if (it.op == OP_LOAD) begin
      gen_words[it.load_address] = it.load_word;
      gen_known[it.load_address] = 1'b1;
    end
    stroke_cmds.push_back(it);
  endtask

  task automatic queue_load(input int addr, input logic [15:0] word);
    vfsg_in_t it;
    it = scrambled(OP_LOAD);
    it.load_address = 12'(addr);
    it.load_word    = word;
    push_cmd(it);
  endtask

  task automatic queue_draw(input int c);
    vfsg_in_t it;
    it = scrambled(OP_DRAW);
    it.char_code = 8'(c);
    push_cmd(it);
  endtask

  task automatic queue_origin(input logic [31:0] x, input logic [31:0] y);
    vfsg_in_t it;
    it = scrambled(OP_ORIGIN);
    it.new_origin_x = x;
    it.new_origin_y = y;
    push_cmd(it);
  endtask

  // Stroke words are mostly well formed; a few carry the special-glyph marks.
  function automatic logic [15:0] pool_word();
    logic [15:0] w;
    w     = 16'($urandom);
    w[15] = ($urandom_range(0, 15) == 0);
    w[14] = ($urandom_range(0, 3) != 0);
    return w;
  endfunction

  // A glyph may be drawn only when every word the decoder touches was loaded.
  function automatic bit glyph_ready(input int g);
    logic [15:0] hdr;
    longint      base;
    int          cnt;
    if (!gen_known[2 * g] || !gen_known[2 * g + 1]) return 0;
    hdr  = gen_words[2 * g];
    base = longint'($signed(gen_words[2 * g + 1]));
    cnt  = (hdr[7:0] > MAX_STROKES) ? MAX_STROKES : hdr[7:0];
    if (cnt == 0) cnt = 1;
    for (int i = 0; i < cnt; i++)
      if (!gen_known[12'(base + i)]) return 0;
    return 1;
  endfunction

  task automatic define_glyph(input int g);
    int          nvec, cnt, pick, base, tries;
    bit          want_plot;
    logic [15:0] ptr;
    pick = $urandom_range(0, 9);
    if (pick < 7) nvec = $urandom_range(0, 6);
    else if (pick < 9) nvec = $urandom_range(7, 20);
    else nvec = $urandom_range(60, 255);
    cnt = (nvec > MAX_STROKES) ? MAX_STROKES : nvec;
    if (cnt == 0) cnt = 1;
    base = POOL_BASE + $urandom_range(0, POOL_WORDS - cnt);
    want_plot = ($urandom_range(0, 5) != 0);
    tries = 0;
    while (want_plot && tries < 8 && gen_words[base][15:14] != STROKE_TAG) begin
      base = POOL_BASE + $urandom_range(0, POOL_WORDS - cnt);
      tries++;
    end
    // The upper nibble of the pointer is free: the address wraps anyway.
    ptr = {4'($urandom), 12'(base)};
    queue_load(2 * g, {8'($urandom), 8'(nvec)});
    queue_load(2 * g + 1, ptr);
  endtask

  task automatic run_random(input int quota);
    int          made, pick, c;
    logic [31:0] x, y;
    made = 0;
    while (made < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        c = $urandom_range(CHAR_FIRST, CHAR_LAST);
        if (!glyph_ready(c - CHAR_FIRST)) begin
          define_glyph(c - CHAR_FIRST);
          made += 2;
        end
        queue_draw(c);
        made++;
      end else if (pick < 58) begin
        define_glyph($urandom_range(0, CHAR_LAST - CHAR_FIRST));
        made += 2;
      end else if (pick < 68) begin
        queue_load(POOL_BASE + $urandom_range(0, POOL_WORDS - 1), pool_word());
        made++;
      end else if (pick < 76) begin
        x = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        y = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        queue_origin(x, y);
        made++;
      end else if (pick < 84) begin
        queue_draw($urandom_range(0, 1) ? $urandom_range(0, CHAR_FIRST - 1)
                                        : $urandom_range(CHAR_LAST + 1, 255));
        made++;
      end else if (pick < 89) begin
        push_cmd(scrambled(OP_UNUSED));
      end else begin
        queue_load($urandom_range(0, FONT_WORDS - 1), 16'($urandom));
        made++;
      end
    end
  endtask

  // ---- configuration -------------------------------------------------------

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_COS:    k_cos = longint'($signed(data));
      CFG_SIN:    k_sin = longint'($signed(data));
      CFG_ASPECT: k_aspect = data[15:0];
      CFG_PEN:    k_pen = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [31:0] c, input logic [31:0] s,
                               input logic [15:0] a, input logic p);
    write_reg(CFG_COS, c);
    write_reg(CFG_SIN, s);
    write_reg(CFG_ASPECT, {16'($urandom), a});
    write_reg(CFG_PEN, {31'($urandom), p});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] moderate_term();
    return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
  endfunction

  // Wait until every command is taken and answered, then let the core go idle.
  task automatic settle();
    while (stroke_cmds.size() != 0 || start || expected_pts.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---- driver --------------------------------------------------------------

  function automatic int next_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = 12;
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        render_cmd(in_item);
        idle_left = next_gap();
      end
      if (start && busy) begin
        // Command still waiting for the core to take it.
      end else if (idle_left > 0) begin
        idle_left--;
        start   <= 1'b0;
        in_item <= scrambled(2'($urandom));
      end else if (stroke_cmds.size() != 0) begin
        start   <= 1'b1;
        in_item <= stroke_cmds.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---- monitor -------------------------------------------------------------

  // Sampled mid-cycle: predictions from this cycle's accept edge are queued.
  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_pts.size() == 0) begin
        flag($sformatf("unexpected beat: x=%0d y=%0d draw=%0b status=%0d last=%0b",
                       out_item.point_x, out_item.point_y, out_item.pen_draw,
                       out_item.status, out_item.last));
      end else begin
        want_pt = expected_pts.pop_front();
        if (out_item.point_x !== want_pt.point_x || out_item.point_y !== want_pt.point_y ||
            out_item.pen_draw !== want_pt.pen_draw || out_item.status !== want_pt.status ||
            out_item.last !== want_pt.last)
          flag($sformatf({"beat mismatch: expected x=%0d y=%0d draw=%0b status=%0d last=%0b,",
                          " got x=%0d y=%0d draw=%0b status=%0d last=%0b"},
                         want_pt.point_x, want_pt.point_y, want_pt.pen_draw,
                         want_pt.status, want_pt.last,
                         out_item.point_x, out_item.point_y, out_item.pen_draw,
                         out_item.status, out_item.last));
      end
    end
  end

  // ---- sequence ------------------------------------------------------------

  initial begin
    logic [15:0] w;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Stroke pool at the top of memory, with coordinate extremes at its start
    // and marker words at its end for the special-glyph and wrap cases.
    for (int k = 0; k < POOL_WORDS; k++) begin
      case (k)
        0:       w = 16'h6040;
        1:       w = 16'h1FBF;
        2:       w = 16'h203F;
        3:       w = 16'h7FFF;
        4:       w = 16'h1FC0;
        5:       w = {2'b01, 14'($urandom)};
        77:      w = 16'h4000;
        78:      w = 16'h0000;
        79:      w = 16'hFFFF;
        default: w = pool_word();
      endcase
      queue_load(POOL_BASE + k, w);
    end

    // Extreme origin: points and the advance saturate.
    queue_origin(32'h7FFF_FFFF, 32'h8000_0000);
    // Three strokes, widest gap, negative list pointer.
    queue_load(0, 16'hFF03);
    queue_load(1, 16'hFFB0);
    queue_draw(32);
    // 255 strokes: cut to the stroke limit and flagged.
    queue_load(188, 16'h00FF);
    queue_load(189, 16'h0FB0);
    queue_draw(126);
    queue_origin(32'h0, 32'h0);
    // No strokes: advance only.
    queue_load(2, 16'h0700);
    queue_load(3, 16'h7FB0);
    queue_draw(33);
    // First stroke word with the sign bit set.
    queue_load(4, 16'h0105);
    queue_load(5, 16'h8FFF);
    queue_draw(34);
    // First stroke word without the move bit.
    queue_load(6, 16'h0002);
    queue_load(7, 16'h0FFE);
    queue_draw(35);
    // Stroke list running past the last address into the header of the space.
    queue_load(8, 16'h0304);
    queue_load(9, 16'hFFFD);
    queue_draw(36);
    // One stroke over the limit.
    queue_load(10, 16'h1441);
    queue_load(11, 16'h0FB5);
    queue_draw(37);
    push_cmd(scrambled(OP_UNUSED));
    queue_draw(0);
    queue_draw(31);
    queue_draw(127);
    queue_draw(255);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b1);
        1:       apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 1'b1);
        2:       apply_setting(moderate_term(), moderate_term(), 16'($urandom), 1'b0);
        3:       apply_setting(moderate_term(), moderate_term(), 16'($urandom), 1'b1);
        4:       apply_setting($urandom, $urandom, 16'($urandom), 1'b1);
        default: apply_setting(32'd16384, 32'd0, 16'd4096, 1'($urandom));
      endcase
      run_random(PHASE_ITEMS);
      settle();
    end

    if (expected_pts.size() != 0)
      flag($sformatf("%0d predicted beats never arrived", expected_pts.size()));
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
